// ----- rtl/pcf_pkg.sv -----
// Shared widths, codes and record types of the per-key chatter filter.
package pcf_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam int CMD_W  = 1;
  localparam int IDX_IN_W = 5;
  localparam int KEY_W  = 8;
  localparam int HOLD_W = 16;
  localparam int TIME_W = 48;
  localparam int CFG_W  = 6;

  // Widest index a table of up to 256 entries needs, plus one bit of headroom.
  localparam int IDX_EXT_W = 9;

  // hold_off_ms times 1000 fits in 26 bits.
  localparam int NEED_W = 26;
  localparam logic [NEED_W-1:0] US_PER_MS = NEED_W'(1000);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PRESS = 1'b1;

  // One entry of the record memory: hold-off delay and time of the last press.
  typedef struct packed {
    logic [HOLD_W-1:0] hold;
    logic [TIME_W-1:0] stamp;
  } pcf_record_t;

  localparam int REC_W = $bits(pcf_record_t);

  // Status handed back from the hold-off check unit.
  typedef struct packed {
    logic done;
    logic pass;
  } pcf_verdict_t;

endpackage

// ----- rtl/pcf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module pcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pcf_hold_check.sv -----
// Two-stage hold-off check: elapsed time and required interval, then the compare.
module pcf_hold_check import pcf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] now,
  input  pcf_record_t       rec,
  output pcf_verdict_t      verdict
);

  logic              s1_valid;
  logic [TIME_W-1:0] elapsed;
  logic [NEED_W-1:0] need;

  // Stage one: modular time difference and the delay scaled to microseconds.
  always_ff @(posedge clk) begin
    elapsed <= now - rec.stamp;
    need    <= {{(NEED_W-HOLD_W){1'b0}}, rec.hold} * US_PER_MS;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  // Stage two: an event passes once the hold-off interval has gone by.
  always_ff @(posedge clk) begin
    verdict.pass <= (elapsed >= TIME_W'(need));
    if (rst) begin
      verdict.done <= 1'b0;
    end else begin
      verdict.done <= s1_valid;
    end
  end

endmodule

// ----- rtl/per_key_chatter_filter_top.sv -----
// Top level of the per-key chatter filter: control sequencer, table memories and result register.
//
// The filter keeps a table of watched keys in two synchronous memories: one holds the
// key codes, the other holds each entry's hold-off delay in milliseconds together with
// the microsecond time of its last press. A load item (command 0) writes one entry,
// stamps it with the item's time and returns a transfer with pass_event and key_matched
// both low. A key event (command 1) scans the code memory one entry per cycle from
// entry 0 up to entries_in_use (saturated to TABLE_ENTRIES), so its cost is set by the
// position of the first matching entry, or by the saturated entries_in_use on a miss.
// A result that finds the output register still full waits for it, and is held back
// for as long as the consumer stalls.
// On a match the record is read, the new time is written back at once, and the event
// passes only if at least hold_off_ms * 1000 microseconds have elapsed, counted modulo
// 2^48; an unmatched key always passes. One item is in work at a time, and the result
// register lets the next item be accepted while an earlier result still waits to be
// taken. The tables have no reset; searching an entry that was never loaded gives an
// undefined answer. entries_in_use should be written only while the block is idle.
module per_key_chatter_filter_top import pcf_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [IDX_IN_W-1:0] entry_index,
  input  logic [KEY_W-1:0]    key_code,
  input  logic [HOLD_W-1:0]   hold_off_ms,
  input  logic [TIME_W-1:0]   time_us,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pass_event,
  output logic                key_matched
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REC_RD,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  entries_in_use;
  logic [KEY_W-1:0]  item_key;
  logic [TIME_W-1:0] item_time;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  scan_cnt;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_idx;
  logic              res_pass;
  logic              res_match;

  logic                 accept;
  logic                 load_ok;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [IDX_W-1:0]     load_addr;
  logic                 hit;
  logic                 scan_end;
  logic                 out_free;

  logic              codes_we;
  logic [KEY_W-1:0]  codes_rdata;
  logic              rec_we;
  logic [IDX_W-1:0]  rec_waddr;
  pcf_record_t       rec_wdata;
  pcf_record_t       rec_rdata;
  pcf_verdict_t      verdict;

  // The block takes a new item only between items; everything after acceptance works
  // from the registered copy of the key and the time.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Loads beyond the table size are dropped but still produce their result.
  assign idx_ext   = {{(IDX_EXT_W-IDX_IN_W){1'b0}}, entry_index};
  assign load_addr = idx_ext[IDX_W-1:0];
  assign load_ok   = accept && (command == CMD_LOAD)
                     && (32'(entry_index) < 32'(TABLE_ENTRIES));

  // The code memory returns the entry addressed in the previous cycle, so the compare
  // runs one entry behind the read address.
  assign hit      = chk_valid && (codes_rdata == item_key);
  assign scan_end = (scan_cnt == limit);

  assign codes_we = load_ok;

  // The record memory is written by a load, or by the time write-back of a matched
  // event in the cycle its old record arrives. Only one item is in work, so the
  // write-back never races a read of the same entry.
  always_comb begin
    rec_we    = load_ok || (state == S_REC_RD);
    rec_waddr = load_addr;
    rec_wdata = '{hold: hold_off_ms, stamp: time_us};
    if (state == S_REC_RD) begin
      rec_waddr = chk_idx;
      rec_wdata = '{hold: rec_rdata.hold, stamp: item_time};
    end
  end

  pcf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_codes_ram (
    .clk   (clk),
    .we    (codes_we),
    .waddr (load_addr),
    .wdata (key_code),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (codes_rdata)
  );

  pcf_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (chk_idx),
    .rdata (rec_rdata)
  );

  pcf_hold_check u_hold_check (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_REC_RD),
    .now     (item_time),
    .rec     (rec_rdata),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= '0;
      limit          <= '0;
      scan_cnt       <= '0;
      chk_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entries_in_use <= cfg_wr_data;
      end
      // A new result fills the output register; otherwise a taken result empties it.
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item_key  <= key_code;
            item_time <= time_us;
            limit     <= (32'(entries_in_use) > 32'(TABLE_ENTRIES))
                         ? CNT_W'(TABLE_ENTRIES) : CNT_W'(entries_in_use);
            scan_cnt  <= '0;
            chk_valid <= 1'b0;
            if (command == CMD_LOAD) begin
              res_pass  <= 1'b0;
              res_match <= 1'b0;
              state     <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit) begin
            // chk_idx now holds the first matching entry and addresses the record read.
            state <= S_REC_RD;
          end else if (scan_end) begin
            res_pass  <= 1'b1;
            res_match <= 1'b0;
            chk_valid <= 1'b0;
            state     <= S_EMIT;
          end else begin
            chk_valid <= 1'b1;
            chk_idx   <= scan_cnt[IDX_W-1:0];
            scan_cnt  <= scan_cnt + CNT_W'(1);
          end
        end

        S_REC_RD: begin
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (verdict.done) begin
            res_pass  <= verdict.pass;
            res_match <= 1'b1;
            state     <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            pass_event  <= res_pass;
            key_matched <= res_match;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An entry under compare always lies inside the searched part of the table.
  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (32'(chk_idx) < 32'(limit)))
    else $error("entry under compare lies beyond the searched range");

  // The check unit only reports while the sequencer waits for it.
  a_verdict_in_check: assert property (@(posedge clk) disable iff (rst)
    verdict.done |-> (state == S_CHECK))
    else $error("hold-off verdict arrived outside the check state");

  // A result leaving the sequencer lands in the output register and frees the input.
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && out_free |=> out_valid && (state == S_IDLE))
    else $error("result was not registered at the output");

  // A time write-back only ever follows a hit on the same entry.
  a_writeback_after_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_REC_RD) |-> $past(hit) && $stable(chk_idx))
    else $error("record write-back without a preceding match");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the per-key chatter filter with a scoreboard and randomized traffic.
`timescale 1ns / 100ps

module testbench;
  import pcf_pkg::*;

  // Cycles allowed for the block to settle after its last result, and the
  // number of cycles with no transfer on either channel that ends the run.
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 9;
  localparam int PHASE_ITEMS     = 120;

  // What the filter should answer for one accepted item.
  typedef struct packed {
    logic pass_event;
    logic key_matched;
  } filter_verdict_t;

  // The scoreboard keeps its own copy of the key table and of the search
  // count, predicts the verdict of every accepted item, and compares each
  // returned result with the oldest verdict still due.
  class chatter_scoreboard;
    logic [KEY_W-1:0]  watched    [TABLE_ENTRIES_DEF];
    logic [HOLD_W-1:0] hold_ms    [TABLE_ENTRIES_DEF];
    logic [TIME_W-1:0] last_press [TABLE_ENTRIES_DEF];
    bit                written    [TABLE_ENTRIES_DEF];
    logic [CFG_W-1:0]  search_count;
    filter_verdict_t   verdicts_due [$];
    int unsigned       errors;

    function new();
      search_count = '0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_search_count(logic [CFG_W-1:0] value);
      search_count = value;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Works out the verdict of one accepted item and updates the table.
    function void predict_verdict(logic [CMD_W-1:0] cmd, logic [IDX_IN_W-1:0] idx,
                                  logic [KEY_W-1:0] code, logic [HOLD_W-1:0] hold,
                                  logic [TIME_W-1:0] now);
      filter_verdict_t   verdict;
      int unsigned       limit;
      bit                found;
      logic [TIME_W-1:0] elapsed;
      logic [NEED_W-1:0] need;
      verdict = '{pass_event: 1'b0, key_matched: 1'b0};
      if (cmd == CMD_LOAD) begin
        // Every 5-bit index lies inside a table of 32 entries.
        watched[idx]    = code;
        hold_ms[idx]    = hold;
        last_press[idx] = now;
        written[idx]    = 1'b1;
      end else begin
        limit = (search_count > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : search_count;
        found = 1'b0;
        verdict = '{pass_event: 1'b1, key_matched: 1'b0};
        for (int i = 0; i < limit && !found; i++) begin
          if (watched[i] == code) begin
            found = 1'b1;
            elapsed = now - last_press[i];
            need = NEED_W'(hold_ms[i]) * US_PER_MS;
            last_press[i] = now;
            verdict.pass_event  = (elapsed < TIME_W'(need)) ? 1'b0 : 1'b1;
            verdict.key_matched = 1'b1;
          end
        end
      end
      verdicts_due.push_back(verdict);
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic pass_seen, logic matched_seen);
      filter_verdict_t due;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result pass_event=%0b key_matched=%0b with nothing due",
                                  pass_seen, matched_seen));
        return;
      end
      due = verdicts_due.pop_front();
      if (pass_seen !== due.pass_event)
        report_mismatch($sformatf("pass_event %0b, predicted %0b", pass_seen, due.pass_event));
      if (matched_seen !== due.key_matched)
        report_mismatch($sformatf("key_matched %0b, predicted %0b",
                                  matched_seen, due.key_matched));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command = CMD_LOAD;
  logic [IDX_IN_W-1:0] entry_index = '0;
  logic [KEY_W-1:0]    key_code = '0;
  logic [HOLD_W-1:0]   hold_off_ms = '0;
  logic [TIME_W-1:0]   time_us = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                pass_event;
  logic                key_matched;

  chatter_scoreboard sb = new();

  // Free-running microsecond clock of the stimulus; it mostly moves forward
  // by human-scale steps and now and then jumps anywhere, wrapping at 2^48.
  logic [TIME_W-1:0] now_us = '0;

  // Random idling on both channels is allowed only while this is set.
  bit gaps_on = 1'b1;

  int stall_left = 0;
  int quiet_cycles = 0;

  per_key_chatter_filter_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .entry_index (entry_index),
    .key_code    (key_code),
    .hold_off_ms (hold_off_ms),
    .time_us     (time_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pass_event  (pass_event),
    .key_matched (key_matched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: every transfer is checked against the scoreboard. Ready drops
  // in random bursts so that finished results back up behind a full output register.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        sb.check_verdict(pass_event, key_matched);
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 15) - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means the
  // block has hung, so the run ends as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("per_key_chatter_filter_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item, holds it until the transfer happens, then hands it to
  // the scoreboard. A random gap may come first; valid stays high otherwise.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_IN_W-1:0] idx,
                           input logic [KEY_W-1:0] code, input logic [HOLD_W-1:0] hold,
                           input logic [TIME_W-1:0] stamp);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    key_code    <= code;
    hold_off_ms <= hold;
    time_us     <= stamp;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.predict_verdict(cmd, idx, code, hold, stamp);
  endtask

  // Stops sending and waits until every predicted result has come back. It
  // always lets at least one edge pass, so valid is never lowered and raised
  // again in the same step.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The search count is changed only with the block idle: all results back,
  // then a pause long enough for the slowest search to finish.
  task automatic write_search_count(input int unsigned value);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_search_count(CFG_W'(value));
  endtask

  // One random item. Loads draw half their codes from a small pool so that duplicates
  // appear in the table; most presses use a code from the searched entries so
  // that matches, drops and first-match ordering are reached often.
  task automatic send_random_item(input int unsigned limit);
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] idx;
    logic [KEY_W-1:0]    code;
    logic [HOLD_W-1:0]   hold;
    int unsigned         pick;
    cmd = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_PRESS;
    idx = IDX_IN_W'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
    hold = ($urandom_range(0, 9) < 8) ? HOLD_W'($urandom_range(0, 60)) : HOLD_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      now_us = now_us + TIME_W'($urandom_range(0, 70000));
    end else if (pick < 16) begin
      now_us = now_us + TIME_W'($urandom_range(0, 2000));
    end else if (pick < 19) begin
      now_us = now_us + TIME_W'($urandom);
    end else begin
      now_us = TIME_W'({$urandom, $urandom});
    end
    if (cmd == CMD_LOAD) begin
      code = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
    end else if (limit != 0 && $urandom_range(0, 4) != 0) begin
      code = sb.watched[$urandom_range(0, limit - 1)];
    end else begin
      code = KEY_W'($urandom);
    end
    send_item(cmd, idx, code, hold, now_us);
  endtask

  initial begin
    int unsigned setting;
    int unsigned limit;
    int unsigned phase_setting [PHASES];
    phase_setting = '{32, 1, 63, 0, 5, 0, 17, 0, 32};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With nothing searched, any key passes unmatched.
    write_search_count(0);
    send_item(CMD_PRESS, 5'd17, 8'h41, 16'hFFFF, 48'd0);
    // Table with the extreme codes, the longest and a zero hold-off, a
    // duplicated code, and a stamp at the top of the time range.
    send_item(CMD_LOAD, 5'd0, 8'h00, 16'd0, 48'h1000);
    send_item(CMD_LOAD, 5'd1, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_LOAD, 5'd2, 8'h5A, 16'd10, 48'd1000);
    send_item(CMD_LOAD, 5'd3, 8'h5A, 16'd0, 48'd2000);
    send_item(CMD_LOAD, 5'd4, 8'hA5, 16'd1, 48'd0);
    send_item(CMD_LOAD, 5'd31, 8'hC3, 16'd7, 48'd3000);
    write_search_count(5);
    // Zero hold-off always passes, even with no time gone by.
    send_item(CMD_PRESS, 5'd31, 8'h00, 16'd0, 48'h1000);
    // Elapsed time wraps through 2^48; then one microsecond short of the
    // hold-off, then exactly the hold-off.
    send_item(CMD_PRESS, 5'd0, 8'hFF, 16'd0, 48'd5);
    send_item(CMD_PRESS, 5'd0, 8'hFF, 16'd0, 48'd65_535_004);
    send_item(CMD_PRESS, 5'd0, 8'hFF, 16'd0, 48'd131_070_004);
    // The duplicated code hits its first entry only.
    send_item(CMD_PRESS, 5'd0, 8'h5A, 16'd0, 48'd10_999);
    send_item(CMD_PRESS, 5'd0, 8'h5A, 16'd0, 48'd20_999);
    send_item(CMD_PRESS, 5'd0, 8'h33, 16'd0, 48'd21_000);
    send_item(CMD_PRESS, 5'd0, 8'hA5, 16'd0, 48'hFFFF_FFFF_FFFF);
    // Entry 31 lies beyond the search count, so its key is unmatched.
    send_item(CMD_PRESS, 5'd0, 8'hC3, 16'd0, 48'd22_000);
    // Overwriting the first duplicate uncovers the second one.
    send_item(CMD_LOAD, 5'd2, 8'h77, 16'd5, 48'd23_000);
    send_item(CMD_PRESS, 5'd0, 8'h5A, 16'd0, 48'd23_001);
    now_us = 48'd23_001;

    // Random part, one search count per phase. Every entry inside the search
    // range is loaded before the count is raised over it, so no search ever
    // reaches an entry that was never written. The last phase runs without
    // idling, and so does one phase in the middle.
    for (int p = 0; p < PHASES; p++) begin
      setting = (p == 5 || p == 7) ? $urandom_range(1, 63) : phase_setting[p];
      limit = (setting > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : setting;
      gaps_on = (p != 2) && (p != PHASES - 1);
      for (int i = 0; i < limit; i++) begin
        if (!sb.written[i])
          send_item(CMD_LOAD, IDX_IN_W'(i), KEY_W'($urandom_range(0, 15)),
                    HOLD_W'($urandom_range(0, 60)), now_us);
      end
      write_search_count(setting);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through each phase but the last, the sender holds off until
        // every result is back, so the block also starts from empty mid-phase.
        if (n == PHASE_ITEMS / 2 && p != PHASES - 1) wait_results_drained();
        send_random_item(limit);
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("per_key_chatter_filter_top verification clean");
    end else begin
      $display("per_key_chatter_filter_top verification failed");
    end
    $finish;
  end

endmodule
